// ===== rtl/lru_key_value_cache_unit_assert.svh =====
// Assertion macros for the LRU key-value cache unit.
// Taken in by the RTL files that carry assertions; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LKV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKV_ASSERT(lbl, clk, rst, prop, msg)
`define LKV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/lkv_pkg.sv =====
// Shared constants, types and codes of the LRU key-value cache.
// No dependencies; used by the interfaces, the cell and the top level.
package lkv_pkg;

   localparam int unsigned ENTRIES = 16;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned CAP_W   = 5;
   localparam int unsigned RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned COUNT_W = $clog2(ENTRIES + 1);

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } lkv_state_type;

   // Broadcast from the control to every cell.
   typedef struct packed {
      logic              lookup;
      logic [KEY_W-1:0]  lookup_key;
      logic              exec;
      logic              is_put;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic              at_cap;
      logic [RANK_W-1:0] oldest_rank;
   } lkv_cmd_type;

   // Resolved hit, fed back from the end of the chain.
   typedef struct packed {
      logic              any_hit;
      logic [RANK_W-1:0] hit_rank;
   } lkv_bcast_type;

   // Passed from cell to cell.
   typedef struct packed {
      logic              found;
      logic              free_taken;
      logic [RANK_W-1:0] rank;
      logic [VAL_W-1:0]  value;
   } lkv_chain_type;

endpackage

// ===== rtl/lkv_if.sv =====
// Valid/ready channel interfaces: request, response and capacity register write.
// Depends on lkv_pkg for the field widths.
interface lkv_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic signed [lkv_pkg::KEY_W-1:0] key;
   logic signed [lkv_pkg::VAL_W-1:0] value;
   modport source (output valid, req_type, key, value, input ready);
   modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic signed [lkv_pkg::VAL_W-1:0] value_out;
   modport source (output valid, hit, value_out, input ready);
   modport sink   (input valid, hit, value_out, output ready);
endinterface

interface lkv_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lkv_pkg::CAP_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
// One cache entry: key, value, valid flag and recency rank, with its link in
// the match, free-slot and readout chain. Depends on lkv_pkg.
module lkv_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lkv_pkg::lkv_cmd_type   cmd,
   input  lkv_pkg::lkv_bcast_type bcast,
   input  lkv_pkg::lkv_chain_type chain_in,
   output lkv_pkg::lkv_chain_type chain_out,
   output logic                   valid
);

   logic                         valid_ff, valid_in;
   logic                         match_ff, match_in;
   logic [lkv_pkg::RANK_W-1:0]   rank_ff, rank_in;
   logic [lkv_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lkv_pkg::VAL_W-1:0]    value_ff, value_in;

   logic sel_hit, insert, evict_me, free_now, ins_me;

   always_comb begin
      sel_hit  = match_ff & ~chain_in.found;
      insert   = cmd.exec & (cmd.is_put == lkv_pkg::OP_PUT) & ~bcast.any_hit;
      evict_me = insert & cmd.at_cap & valid_ff & (rank_ff == cmd.oldest_rank);
      free_now = ~valid_ff | evict_me;
      ins_me   = insert & free_now & ~chain_in.free_taken;

      chain_out.found      = chain_in.found | match_ff;
      chain_out.free_taken = chain_in.free_taken | free_now;
      chain_out.rank       = chain_in.rank | (sel_hit ? rank_ff : '0);
      chain_out.value      = chain_in.value | (sel_hit ? value_ff : '0);
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (cmd.lookup) begin
         match_in = valid_ff && (key_ff == cmd.lookup_key);
      end
      if (cmd.exec) begin
         if (bcast.any_hit) begin
            if (sel_hit) begin
               rank_in = '0;
               if (cmd.is_put == lkv_pkg::OP_PUT) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < bcast.hit_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (insert) begin
            if (ins_me) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               rank_in  = '0;
            end else if (evict_me) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// Fully associative key-value cache with least-recently-used replacement, built
// as a row of lkv_pkg::ENTRIES entry cells. On the edge that accepts a request,
// every cell compares its key with the request key; in the next cycle the hit,
// free-slot and readout chains through the cells resolve and all entries update
// their ranks, so no new request is taken until the last one has executed. A
// get's response is registered at the end of the execute cycle; a put gives
// no response. Requests are held off while an untaken response is waiting.
// Depends on lkv_pkg, lkv_if.sv, lkv_cell and the assertion macro header.
`include "lru_key_value_cache_unit_assert.svh"

module lru_key_value_cache_unit (
   input  logic      clock,
   input  logic      reset,
   lkv_req_if.sink   req,
   lkv_rsp_if.source rsp,
   lkv_csr_if.sink   csr
);

   lkv_pkg::lkv_state_type state_ff, state_in;

   logic [lkv_pkg::CAP_W-1:0]   cap_ff;
   logic [lkv_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lkv_pkg::COUNT_W-1:0] cap_eff;
   logic                        op_ff;
   logic [lkv_pkg::KEY_W-1:0]   key_ff;
   logic [lkv_pkg::VAL_W-1:0]   value_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff;
   logic [lkv_pkg::VAL_W-1:0]   rsp_value_ff;

   logic req_ready, req_fire, do_lookup, do_exec, at_cap, put_insert;

   lkv_pkg::lkv_cmd_type   cmd;
   lkv_pkg::lkv_bcast_type bcast;
   lkv_pkg::lkv_chain_type chain [lkv_pkg::ENTRIES+1];
   logic [lkv_pkg::ENTRIES-1:0] valid_vec;

   assign req_fire = req.valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (req_fire) state_in = lkv_pkg::ST_EXEC;
         end
         lkv_pkg::ST_EXEC: begin
            state_in = lkv_pkg::ST_IDLE;
         end
         default: state_in = lkv_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      do_lookup = 1'b0;
      do_exec   = 1'b0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp.ready;
            do_lookup = req.valid && req_ready;
         end
         lkv_pkg::ST_EXEC: begin
            do_exec = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = lkv_pkg::COUNT_W'(1);
      end else if (32'(cap_ff) > lkv_pkg::ENTRIES) begin
         cap_eff = lkv_pkg::COUNT_W'(lkv_pkg::ENTRIES);
      end else begin
         cap_eff = lkv_pkg::COUNT_W'(cap_ff);
      end
      at_cap = count_ff >= cap_eff;
   end

   always_comb begin
      cmd.lookup      = do_lookup;
      cmd.lookup_key  = req.key;
      cmd.exec        = do_exec;
      cmd.is_put      = op_ff;
      cmd.key         = key_ff;
      cmd.value       = value_ff;
      cmd.at_cap      = at_cap;
      cmd.oldest_rank = lkv_pkg::RANK_W'(count_ff - 1'b1);
   end

   assign chain[0] = '0;
   assign bcast.any_hit  = chain[lkv_pkg::ENTRIES].found;
   assign bcast.hit_rank = chain[lkv_pkg::ENTRIES].rank;

   for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .bcast     (bcast),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .valid     (valid_vec[i])
      );
   end

   assign put_insert = do_exec && (op_ff == lkv_pkg::OP_PUT) && !bcast.any_hit;

   always_comb begin
      count_in = count_ff;
      if (put_insert && !at_cap) count_in = count_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (do_exec && (op_ff == lkv_pkg::OP_GET)) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         cap_ff       <= lkv_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) cap_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req.req_type;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
      if (do_exec && (op_ff == lkv_pkg::OP_GET)) begin
         rsp_hit_ff   <= bcast.any_hit;
         rsp_value_ff <= bcast.any_hit ? chain[lkv_pkg::ENTRIES].value : lkv_pkg::MISS_VALUE;
      end
   end

   assign req.ready     = req_ready;
   assign csr.ready     = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.value_out = rsp_value_ff;

   `LKV_ASSERT(a_exec_single, clock, reset, state_ff == lkv_pkg::ST_EXEC |=> state_ff == lkv_pkg::ST_IDLE, "exec phase lasted more than one cycle")
   `LKV_ASSERT(a_accept_exec, clock, reset, req_fire |=> state_ff == lkv_pkg::ST_EXEC, "accepted request not executed")
   `LKV_ASSERT(a_rsp_slot_free, clock, reset, (do_exec && op_ff == lkv_pkg::OP_GET) |-> !rsp_valid_ff, "get executed while response slot busy")
   `LKV_ASSERT(a_count_valid, clock, reset, lkv_pkg::COUNT_W'($countones(valid_vec)) == count_ff, "entry count differs from valid entries")
   `LKV_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> count_ff == '0, "cache not empty after reset")

endmodule
